@@ sv/tgad_pkg.sv @@
`default_nettype none

package tgad_pkg;

    // Parser phase: header bytes, pixel bytes, then wait for end of file.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXELS = 2'd1,
        PH_IDLE   = 2'd2
    } t_phase;

    // Result kinds (carried on tuser)
    localparam logic [1:0] KIND_INFO  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_HEADER_SHORT = 3'd1;
    localparam logic [2:0] ERR_BAD_SPEC     = 3'd2;
    localparam logic [2:0] ERR_ORIGIN       = 3'd3;
    localparam logic [2:0] ERR_ZERO_AREA    = 3'd4;
    localparam logic [2:0] ERR_DEPTH        = 3'd5;
    localparam logic [2:0] ERR_DATA_SHORT   = 3'd6;

    // Header byte positions
    localparam logic [4:0] POS_IMAGE_TYPE = 5'd2;
    localparam logic [4:0] POS_WIDTH_LO   = 5'd12;
    localparam logic [4:0] POS_WIDTH_HI   = 5'd13;
    localparam logic [4:0] POS_HEIGHT_LO  = 5'd14;
    localparam logic [4:0] POS_HEIGHT_HI  = 5'd15;
    localparam logic [4:0] POS_DEPTH      = 5'd16;
    localparam logic [4:0] POS_ATTR       = 5'd17;

    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;
    localparam int         ATTR_TOP_BIT   = 5;

    // Packed output word width: 100 bits of fields padded to 13 bytes
    localparam int OUT_DATA_W = 104;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        has_alpha;
        logic [15:0] column;
        logic [15:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_pixel;
    } t_result;

    // Results produced by one accepted byte: none, one or two.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

`default_nettype wire

@@ sv/tga_uncompressed_decoder.sv @@
// Channel | Dir | Handshake           | Payload
// s       | in  | i_s_tvalid/o_s_tready | tdata: data_byte; tlast: end_of_file
// m       | out | o_m_tvalid/i_m_tready | tuser: kind; tlast: last_pixel;
//         |     |                     | tdata: error_code..alpha (see port)
//
// One byte is taken per cycle while input ready is high; the parser state
// advances at the handshake and its results land in a three-word queue at
// the same clock edge. A byte causes zero, one or two results (two only on
// end of file). With the sink taking one word per cycle the rate is one
// byte per cycle, except that an end-of-file byte bringing two words can
// drop input ready. Input ready drops whenever two or more words wait in
// the queue. Reset is synchronous and active low; it clears the parser and
// empties the queue. End of file rearms the parser for the next file.
`default_nettype none

module tga_uncompressed_decoder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  wire logic         i_s_tlast,   // end_of_file
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [2:0] error_code, [18:3] image_width, [34:19] image_height,
    // [35] has_alpha, [51:36] column, [67:52] row, [75:68] red,
    // [83:76] green, [91:84] blue, [99:92] alpha, [103:100] zero
    output logic [tgad_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [1:0]        o_m_tuser,   // [1:0] kind
    output logic              o_m_tlast    // last_pixel
);

    // Parser state
    tgad_pkg::t_phase r_phase, n_phase;
    logic [4:0]       r_pos, n_pos;
    logic [2:0]       r_fault, n_fault;
    logic [15:0]      r_width, n_width;
    logic [15:0]      r_height, n_height;
    logic             r_four, n_four;
    logic             r_mirror, n_mirror;
    logic [15:0]      r_col, n_col;
    logic [15:0]      r_row, n_row;
    logic [1:0]       r_idx, n_idx;
    logic [7:0]       r_pix [3];
    logic [7:0]       n_pix [3];

    logic              w_accept;
    logic [7:0]        w_byte;
    logic [2:0]        w_fault_now;
    logic              w_pix_done;
    logic              w_col_wrap;
    logic              w_row_end;
    logic              w_last;
    tgad_pkg::t_phase  w_step_phase;
    logic              w_step_vld;
    logic              w_eof_vld;
    tgad_pkg::t_result w_step_res;
    tgad_pkg::t_result w_eof_res;
    tgad_pkg::t_push   w_push;
    tgad_pkg::t_result w_head;
    logic              w_room;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_byte     = i_s_tdata;
    assign o_s_tready = w_room;

    // Fault seen at this header byte, before precedence
    always_comb begin
        w_fault_now = tgad_pkg::ERR_NONE;
        unique case (r_pos) inside
            [5'd0:5'd7]: begin
                if (w_byte != ((r_pos == tgad_pkg::POS_IMAGE_TYPE) ?
                               tgad_pkg::TYPE_TRUECOLOR : 8'd0)) begin
                    w_fault_now = tgad_pkg::ERR_BAD_SPEC;
                end
            end
            [5'd8:5'd11]: begin
                if (w_byte != 8'd0) begin
                    w_fault_now = tgad_pkg::ERR_ORIGIN;
                end
            end
            tgad_pkg::POS_HEIGHT_HI: begin
                if ((r_width == 16'd0) || ({w_byte, r_height[7:0]} == 16'd0)) begin
                    w_fault_now = tgad_pkg::ERR_ZERO_AREA;
                end
            end
            tgad_pkg::POS_DEPTH: begin
                if ((w_byte != tgad_pkg::DEPTH_24) && (w_byte != tgad_pkg::DEPTH_32)) begin
                    w_fault_now = tgad_pkg::ERR_DEPTH;
                end
            end
            default: w_fault_now = tgad_pkg::ERR_NONE;
        endcase
    end

    // Pixel position bookkeeping; width and height are nonzero here
    assign w_pix_done = (r_idx >= (r_four ? 2'd3 : 2'd2));
    assign w_col_wrap = ({1'b0, r_col} + 17'd1) >= {1'b0, r_width};
    assign w_row_end  = ({1'b0, r_row} + 17'd1) >= {1'b0, r_height};
    assign w_last     = w_col_wrap && w_row_end;

    // Phase after this byte, before any end-of-file rearm
    always_comb begin
        w_step_phase = r_phase;
        if ((r_phase == tgad_pkg::PH_HEADER) && (r_pos == tgad_pkg::POS_ATTR)) begin
            w_step_phase = (r_fault != tgad_pkg::ERR_NONE) ? tgad_pkg::PH_IDLE :
                                                             tgad_pkg::PH_PIXELS;
        end else if ((r_phase == tgad_pkg::PH_PIXELS) && w_pix_done && w_last) begin
            w_step_phase = tgad_pkg::PH_IDLE;
        end
    end

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_fault  = r_fault;
        n_width  = r_width;
        n_height = r_height;
        n_four   = r_four;
        n_mirror = r_mirror;
        n_col    = r_col;
        n_row    = r_row;
        n_idx    = r_idx;
        n_pix    = r_pix;
        if (w_accept) begin
            n_phase = w_step_phase;
            unique case (r_phase)
                tgad_pkg::PH_HEADER: begin
                    if (r_pos == tgad_pkg::POS_ATTR) begin
                        n_mirror = w_byte[tgad_pkg::ATTR_TOP_BIT];
                        n_pos    = 5'd0;
                        n_col    = 16'd0;
                        n_row    = 16'd0;
                        n_idx    = 2'd0;
                    end else begin
                        n_pos = r_pos + 5'd1;
                        if (r_fault == tgad_pkg::ERR_NONE) begin
                            n_fault = w_fault_now;
                        end
                        unique case (r_pos)
                            tgad_pkg::POS_WIDTH_LO:  n_width  = {8'd0, w_byte};
                            tgad_pkg::POS_WIDTH_HI:  n_width  = {w_byte, r_width[7:0]};
                            tgad_pkg::POS_HEIGHT_LO: n_height = {8'd0, w_byte};
                            tgad_pkg::POS_HEIGHT_HI: n_height = {w_byte, r_height[7:0]};
                            tgad_pkg::POS_DEPTH: begin
                                if (w_byte == tgad_pkg::DEPTH_24) begin
                                    n_four = 1'b0;
                                end else if (w_byte == tgad_pkg::DEPTH_32) begin
                                    n_four = 1'b1;
                                end
                            end
                            default: n_four = r_four;
                        endcase
                    end
                end
                tgad_pkg::PH_PIXELS: begin
                    if (!w_pix_done) begin
                        n_pix[r_idx] = w_byte;
                        n_idx        = r_idx + 2'd1;
                    end else begin
                        n_idx = 2'd0;
                        if (!w_last) begin
                            if (w_col_wrap) begin
                                n_col = 16'd0;
                                n_row = r_row + 16'd1;
                            end else begin
                                n_col = r_col + 16'd1;
                            end
                        end
                    end
                end
                tgad_pkg::PH_IDLE: begin
                    n_phase = r_phase;
                end
                default: n_phase = tgad_pkg::PH_HEADER;
            endcase
            // Rearm for the next file; pixel bytes keep their contents
            if (i_s_tlast) begin
                n_phase  = tgad_pkg::PH_HEADER;
                n_pos    = 5'd0;
                n_fault  = tgad_pkg::ERR_NONE;
                n_width  = 16'd0;
                n_height = 16'd0;
                n_four   = 1'b0;
                n_mirror = 1'b0;
                n_col    = 16'd0;
                n_row    = 16'd0;
                n_idx    = 2'd0;
            end
        end
    end

    // Results for this byte
    always_comb begin
        w_step_res = '0;
        w_step_vld = 1'b0;
        if (w_accept) begin
            unique case (r_phase)
                tgad_pkg::PH_HEADER: begin
                    if (r_pos == tgad_pkg::POS_ATTR) begin
                        w_step_vld = 1'b1;
                        if (r_fault != tgad_pkg::ERR_NONE) begin
                            w_step_res.kind       = tgad_pkg::KIND_ERROR;
                            w_step_res.error_code = r_fault;
                        end else begin
                            w_step_res.kind         = tgad_pkg::KIND_INFO;
                            w_step_res.image_width  = r_width;
                            w_step_res.image_height = r_height;
                            w_step_res.has_alpha    = r_four;
                        end
                    end
                end
                tgad_pkg::PH_PIXELS: begin
                    if (w_pix_done) begin
                        w_step_vld              = 1'b1;
                        w_step_res.kind         = tgad_pkg::KIND_PIXEL;
                        w_step_res.image_width  = r_width;
                        w_step_res.image_height = r_height;
                        w_step_res.has_alpha    = r_four;
                        w_step_res.column       = r_col;
                        w_step_res.row          = r_mirror ? (r_height - 16'd1 - r_row) : r_row;
                        w_step_res.green        = r_pix[1];
                        w_step_res.blue         = r_pix[0];
                        w_step_res.red          = r_four ? r_pix[2] : w_byte;
                        w_step_res.alpha        = r_four ? w_byte : 8'd0;
                        w_step_res.last_pixel   = w_last;
                    end
                end
                tgad_pkg::PH_IDLE: w_step_vld = 1'b0;
                default:           w_step_vld = 1'b0;
            endcase
        end

        // End of file while header or pixels are still open
        w_eof_vld            = w_accept && i_s_tlast && (w_step_phase != tgad_pkg::PH_IDLE);
        w_eof_res            = '0;
        w_eof_res.kind       = tgad_pkg::KIND_ERROR;
        w_eof_res.error_code = (w_step_phase == tgad_pkg::PH_HEADER) ?
                               tgad_pkg::ERR_HEADER_SHORT : tgad_pkg::ERR_DATA_SHORT;

        w_push.count  = {1'b0, w_step_vld} + {1'b0, w_eof_vld};
        w_push.first  = w_step_vld ? w_step_res : w_eof_res;
        w_push.second = w_eof_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= tgad_pkg::PH_HEADER;
            r_pos    <= 5'd0;
            r_fault  <= tgad_pkg::ERR_NONE;
            r_width  <= 16'd0;
            r_height <= 16'd0;
            r_four   <= 1'b0;
            r_mirror <= 1'b0;
            r_col    <= 16'd0;
            r_row    <= 16'd0;
            r_idx    <= 2'd0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_fault  <= n_fault;
            r_width  <= n_width;
            r_height <= n_height;
            r_four   <= n_four;
            r_mirror <= n_mirror;
            r_col    <= n_col;
            r_row    <= n_row;
            r_idx    <= n_idx;
        end
    end

    // Pixel byte holding registers: payload, no reset
    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    tgad_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_m_tready),
        .o_room  (w_room),
        .o_valid (o_m_tvalid),
        .o_head  (w_head)
    );

    assign o_m_tuser = w_head.kind;
    assign o_m_tlast = w_head.last_pixel;
    assign o_m_tdata = {4'd0, w_head.alpha, w_head.blue, w_head.green, w_head.red,
                        w_head.row, w_head.column, w_head.has_alpha,
                        w_head.image_height, w_head.image_width, w_head.error_code};

endmodule

`default_nettype wire

@@ sv/tgad_res_queue.sv @@
`default_nettype none

// Three-word result queue: takes up to two words a cycle, gives one.
module tgad_res_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tgad_pkg::t_push  i_push,
    input  wire logic             i_pop,
    output logic                  o_room,
    output logic                  o_valid,
    output tgad_pkg::t_result     o_head
);

    localparam int DEPTH = 3;

    tgad_pkg::t_result r_ent [DEPTH];
    tgad_pkg::t_result n_ent [DEPTH];
    logic [1:0]        r_count;
    logic [1:0]        n_count;
    logic [1:0]        w_mid;
    logic              w_pop;

    assign w_pop   = i_pop && (r_count != 2'd0);
    assign w_mid   = r_count - {1'b0, w_pop};
    assign o_room  = (r_count <= 2'd1);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_ent[0];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (w_pop && (i < DEPTH - 1)) begin
                n_ent[i] = r_ent[i + 1];
            end else begin
                n_ent[i] = r_ent[i];
            end
            if ((i == int'(w_mid)) && (i_push.count != 2'd0)) begin
                n_ent[i] = i_push.first;
            end
            if ((i == int'(w_mid) + 1) && (i_push.count == 2'd2)) begin
                n_ent[i] = i_push.second;
            end
        end
        n_count = w_mid + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

`default_nettype wire

@@ sv/tgad_checker.sv @@
`default_nettype none

module tgad_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic [7:0]                    i_s_tdata,
    input wire logic                          i_s_tlast,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [tgad_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input wire logic [1:0]                    o_m_tuser,
    input wire logic                          o_m_tlast
);

    // Stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
                                      $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result word changed");

    // Error words carry only the code
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == tgad_pkg::KIND_ERROR) |->
            (o_m_tdata[tgad_pkg::OUT_DATA_W-1:3] == '0) && !o_m_tlast &&
            (o_m_tdata[2:0] != tgad_pkg::ERR_NONE))
        else $error("error word with stray payload");

    // Only pixels may be marked last, and non-error words carry no code
    a_last_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != tgad_pkg::KIND_ERROR) |->
            (o_m_tdata[2:0] == tgad_pkg::ERR_NONE) &&
            (!o_m_tlast || (o_m_tuser == tgad_pkg::KIND_PIXEL)))
        else $error("non-error word with code or misplaced last flag");

    // Pixel words fall inside the announced image
    a_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == tgad_pkg::KIND_PIXEL) |->
            (o_m_tdata[51:36] < o_m_tdata[18:3]) && (o_m_tdata[67:52] < o_m_tdata[34:19]))
        else $error("pixel outside the image");

endmodule

bind tga_uncompressed_decoder tgad_checker u_tgad_checker (.*);

`default_nettype wire

@@ bench/tb_tga_uncompressed_decoder.sv @@
`default_nettype none

// Mirror of the decoder, fed with every accepted input word. It holds the
// words the block should emit and checks each emitted word against the
// oldest one.
class decode_scoreboard;
    localparam logic [4:0] POS_X_ORIGIN = 5'd8;
    localparam int         MAX_LINES    = 40;

    tgad_pkg::t_result pending_words[$];
    int                errors;

    // Decoder state
    logic [4:0]       hdr_pos;
    logic [2:0]       hdr_fault;
    logic [15:0]      img_w;
    logic [15:0]      img_h;
    logic             rgba;
    logic             flip;
    tgad_pkg::t_phase stage;
    logic [15:0]      col_cnt;
    logic [15:0]      row_cnt;
    logic [7:0]       chan[3];
    logic [1:0]       chan_idx;

    function new();
        errors = 0;
        rearm();
    endfunction

    // Return to the state of a fresh file.
    function void rearm();
        hdr_pos   = 5'd0;
        hdr_fault = tgad_pkg::ERR_NONE;
        img_w     = 16'd0;
        img_h     = 16'd0;
        rgba      = 1'b0;
        flip      = 1'b0;
        stage     = tgad_pkg::PH_HEADER;
        col_cnt   = 16'd0;
        row_cnt   = 16'd0;
        chan[0]   = 8'd0;
        chan[1]   = 8'd0;
        chan[2]   = 8'd0;
        chan_idx  = 2'd0;
    endfunction

    function void push_error(logic [2:0] code);
        tgad_pkg::t_result r;
        r            = '0;
        r.kind       = tgad_pkg::KIND_ERROR;
        r.error_code = code;
        pending_words.push_back(r);
    endfunction

    // Keep only the first header fault.
    function void flag(logic [2:0] code);
        if (hdr_fault == tgad_pkg::ERR_NONE)
            hdr_fault = code;
    endfunction

    function void header_byte(logic [7:0] b);
        tgad_pkg::t_result r;
        if (hdr_pos < POS_X_ORIGIN) begin
            if (b != ((hdr_pos == tgad_pkg::POS_IMAGE_TYPE) ?
                      tgad_pkg::TYPE_TRUECOLOR : 8'd0))
                flag(tgad_pkg::ERR_BAD_SPEC);
        end else if (hdr_pos < tgad_pkg::POS_WIDTH_LO) begin
            if (b != 8'd0)
                flag(tgad_pkg::ERR_ORIGIN);
        end else if (hdr_pos == tgad_pkg::POS_WIDTH_LO) begin
            img_w = {8'd0, b};
        end else if (hdr_pos == tgad_pkg::POS_WIDTH_HI) begin
            img_w[15:8] = b;
        end else if (hdr_pos == tgad_pkg::POS_HEIGHT_LO) begin
            img_h = {8'd0, b};
        end else if (hdr_pos == tgad_pkg::POS_HEIGHT_HI) begin
            img_h[15:8] = b;
            if (img_w == 16'd0 || img_h == 16'd0)
                flag(tgad_pkg::ERR_ZERO_AREA);
        end else if (hdr_pos == tgad_pkg::POS_DEPTH) begin
            if (b == tgad_pkg::DEPTH_24)
                rgba = 1'b0;
            else if (b == tgad_pkg::DEPTH_32)
                rgba = 1'b1;
            else
                flag(tgad_pkg::ERR_DEPTH);
        end else begin
            // Attribute byte closes the header.
            flip    = b[tgad_pkg::ATTR_TOP_BIT];
            hdr_pos = 5'd0;
            if (hdr_fault != tgad_pkg::ERR_NONE) begin
                stage = tgad_pkg::PH_IDLE;
                push_error(hdr_fault);
            end else begin
                r              = '0;
                r.kind         = tgad_pkg::KIND_INFO;
                r.image_width  = img_w;
                r.image_height = img_h;
                r.has_alpha    = rgba;
                pending_words.push_back(r);
                stage    = tgad_pkg::PH_PIXELS;
                col_cnt  = 16'd0;
                row_cnt  = 16'd0;
                chan_idx = 2'd0;
            end
            return;
        end
        hdr_pos = hdr_pos + 5'd1;
    endfunction

    function void pixel_byte(logic [7:0] b);
        tgad_pkg::t_result r;
        logic [2:0]        need;
        logic              row_end;
        logic              at_end;
        need = rgba ? 3'd4 : 3'd3;
        if ({1'b0, chan_idx} + 3'd1 < need) begin
            chan[chan_idx] = b;
            chan_idx       = chan_idx + 2'd1;
            return;
        end
        chan_idx = 2'd0;
        row_end  = (17'(col_cnt) + 17'd1 >= 17'(img_w));
        at_end   = row_end && (17'(row_cnt) + 17'd1 >= 17'(img_h));

        r              = '0;
        r.kind         = tgad_pkg::KIND_PIXEL;
        r.image_width  = img_w;
        r.image_height = img_h;
        r.has_alpha    = rgba;
        r.column       = col_cnt;
        r.row          = flip ? (img_h - 16'd1 - row_cnt) : row_cnt;
        r.green        = chan[1];
        r.blue         = chan[0];
        if (rgba) begin
            r.red   = chan[2];
            r.alpha = b;
        end else begin
            r.red   = b;
            r.alpha = 8'd0;
        end
        r.last_pixel = at_end;
        pending_words.push_back(r);

        if (at_end) begin
            stage = tgad_pkg::PH_IDLE;
        end else if (row_end) begin
            col_cnt = 16'd0;
            row_cnt = row_cnt + 16'd1;
        end else begin
            col_cnt = col_cnt + 16'd1;
        end
    endfunction

    // Advance the mirror by one accepted input word.
    function void note_input(logic [7:0] b, logic eof);
        case (stage)
            tgad_pkg::PH_HEADER: header_byte(b);
            tgad_pkg::PH_PIXELS: pixel_byte(b);
            default: ;
        endcase
        if (eof) begin
            if (stage == tgad_pkg::PH_HEADER)
                push_error(tgad_pkg::ERR_HEADER_SHORT);
            else if (stage == tgad_pkg::PH_PIXELS)
                push_error(tgad_pkg::ERR_DATA_SHORT);
            rearm();
        end
    endfunction

    function int pending();
        return pending_words.size();
    endfunction

    task report_mismatch(string msg);
        if (errors < MAX_LINES)
            $display("%0t ns: mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(tgad_pkg::t_result got);
        tgad_pkg::t_result want;
        if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d code %0d",
                                      got.kind, got.error_code));
            return;
        end
        want = pending_words.pop_front();
        compare_field("kind",         got.kind,         want.kind);
        compare_field("error_code",   got.error_code,   want.error_code);
        compare_field("image_width",  got.image_width,  want.image_width);
        compare_field("image_height", got.image_height, want.image_height);
        compare_field("has_alpha",    got.has_alpha,    want.has_alpha);
        compare_field("column",       got.column,       want.column);
        compare_field("row",          got.row,          want.row);
        compare_field("red",          got.red,          want.red);
        compare_field("green",        got.green,        want.green);
        compare_field("blue",         got.blue,         want.blue);
        compare_field("alpha",        got.alpha,        want.alpha);
        compare_field("last_pixel",   got.last_pixel,   want.last_pixel);
    endtask
endclass

module tb_tga_uncompressed_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR_BYTES      = 18;
    localparam int RESET_CYCLES   = 5;
    localparam int INPUT_BYTES    = 950;
    localparam int IDLE_PCT       = 35;
    // Both sides run without gaps inside this window of cycles.
    localparam int CALM_FIRST     = 400;
    localparam int CALM_LAST      = 1200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    // One input word: a file byte and its end-of-file mark.
    typedef struct packed {
        logic       eof;
        logic [7:0] value;
    } t_in_word;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'd0;
    logic        i_s_tlast  = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [tgad_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    tgad_pkg::t_result out_word;
    decode_scoreboard  scoreboard;
    t_in_word          file_stream[$];
    logic [7:0]        hdr[HDR_BYTES];
    int                cycle_cnt = 0;
    int                quiet_cnt = 0;
    logic              calm;

    tga_uncompressed_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Unpack the output word, fields from the lowest bit of tdata up.
    always_comb begin
        out_word.kind         = o_m_tuser;
        out_word.error_code   = o_m_tdata[2:0];
        out_word.image_width  = o_m_tdata[18:3];
        out_word.image_height = o_m_tdata[34:19];
        out_word.has_alpha    = o_m_tdata[35];
        out_word.column       = o_m_tdata[51:36];
        out_word.row          = o_m_tdata[67:52];
        out_word.red          = o_m_tdata[75:68];
        out_word.green        = o_m_tdata[83:76];
        out_word.blue         = o_m_tdata[91:84];
        out_word.alpha        = o_m_tdata[99:92];
        out_word.last_pixel   = o_m_tlast;
    end

    assign calm = (cycle_cnt >= CALM_FIRST) && (cycle_cnt < CALM_LAST);

    // Roll the dice for one idle cycle; never idle inside the calm window.
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Count cycles and bail out when neither side moves a word for too long.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sink: stall at random, hold ready low while in reset.
    always @(posedge i_clk) begin
        i_m_tready <= i_rst_n && !take_break();
    end

    // Monitor: feed accepted input words to the mirror first, then check
    // any output word taken at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                scoreboard.note_input(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                scoreboard.check_result(out_word);
        end
    end

    // Fill the header template with a well-formed uncompressed header.
    task automatic start_header(logic [15:0] w, logic [15:0] h,
                                logic [7:0] depth, logic [7:0] attr);
        for (int i = 0; i < HDR_BYTES; i++)
            hdr[i] = 8'd0;
        hdr[tgad_pkg::POS_IMAGE_TYPE] = tgad_pkg::TYPE_TRUECOLOR;
        hdr[tgad_pkg::POS_WIDTH_LO]   = w[7:0];
        hdr[tgad_pkg::POS_WIDTH_HI]   = w[15:8];
        hdr[tgad_pkg::POS_HEIGHT_LO]  = h[7:0];
        hdr[tgad_pkg::POS_HEIGHT_HI]  = h[15:8];
        hdr[tgad_pkg::POS_DEPTH]      = depth;
        hdr[tgad_pkg::POS_ATTR]       = attr;
    endtask

    // Queue one file: header, random pixel bytes, random trailing junk.
    // A cut of zero or more ends the file at that byte index.
    task automatic emit_file(int pix_bytes, int trail, int cut);
        t_in_word w;
        int       total;
        total = HDR_BYTES + pix_bytes + trail;
        if (cut >= 0 && cut < total)
            total = cut + 1;
        for (int i = 0; i < total; i++) begin
            w.value = (i < HDR_BYTES) ? hdr[i] : 8'($urandom_range(255));
            w.eof   = (i == total - 1);
            file_stream.push_back(w);
        end
    endtask

    task automatic build_stimulus();
        int          sel;
        int          bpp;
        int          px;
        int          pos;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  depth;
        logic [7:0]  d;

        // Smallest image, end of file on its last pixel byte.
        start_header(16'd1, 16'd1, tgad_pkg::DEPTH_24, 8'h00);
        emit_file(3, 0, -1);
        // 32-bit, rows mirrored, junk after the final pixel.
        start_header(16'd2, 16'd2, tgad_pkg::DEPTH_32, 8'h20);
        emit_file(16, 2, -1);
        // Largest area, all attribute bits set; data ends mid pixel.
        start_header(16'hFFFF, 16'hFFFF, tgad_pkg::DEPTH_32, 8'hFF);
        emit_file(9, 0, -1);
        // Widest single row, 24-bit, data ends after two pixels.
        start_header(16'hFFFF, 16'd1, tgad_pkg::DEPTH_24, 8'hDF);
        emit_file(6, 0, -1);
        // End of file on the attribute byte of a good header.
        start_header(16'd3, 16'd1, tgad_pkg::DEPTH_24, 8'h00);
        emit_file(0, 0, tgad_pkg::POS_ATTR);
        // End of file on the very first byte.
        emit_file(9, 0, 0);
        // Header cut short while a depth fault is pending.
        start_header(16'd1, 16'd1, 8'd16, 8'h00);
        emit_file(0, 0, tgad_pkg::POS_DEPTH);
        // Bad image type and nonzero origin: only the first is reported.
        start_header(16'd1, 16'd1, tgad_pkg::DEPTH_24, 8'h00);
        hdr[tgad_pkg::POS_IMAGE_TYPE] = 8'd3;
        hdr[9]                        = 8'h80;
        emit_file(3, 2, -1);
        // Bad leading byte.
        start_header(16'd1, 16'd1, tgad_pkg::DEPTH_24, 8'h00);
        hdr[0] = 8'hFF;
        emit_file(0, 1, -1);
        // Nonzero origin.
        start_header(16'd1, 16'd1, tgad_pkg::DEPTH_24, 8'h00);
        hdr[11] = 8'h01;
        emit_file(3, 0, -1);
        // Zero width, then zero height.
        start_header(16'd0, 16'd5, tgad_pkg::DEPTH_24, 8'h00);
        emit_file(3, 0, -1);
        start_header(16'd5, 16'd0, tgad_pkg::DEPTH_32, 8'h20);
        emit_file(0, 0, -1);
        // Unsupported depth.
        start_header(16'd1, 16'd1, 8'd33, 8'h00);
        emit_file(4, 0, -1);

        // Fill up with random files until the byte budget is spent.
        while (file_stream.size() < INPUT_BYTES) begin
            sel   = $urandom_range(99);
            w     = ($urandom_range(9) == 0) ? 16'($urandom_range(5, 12))
                                             : 16'($urandom_range(1, 4));
            h     = 16'($urandom_range(1, 3));
            depth = $urandom_range(1) ? tgad_pkg::DEPTH_32 : tgad_pkg::DEPTH_24;
            bpp   = (depth == tgad_pkg::DEPTH_32) ? 4 : 3;
            px    = int'(w) * int'(h) * bpp;
            start_header(w, h, depth, 8'($urandom_range(255)));
            if (sel < 60) begin
                // Whole image, sometimes with junk behind it.
                emit_file(px, $urandom_range(1) ? 0 : $urandom_range(1, 4), -1);
            end else if (sel < 72) begin
                // Data ends anywhere from the attribute byte on.
                emit_file(px, 0, $urandom_range(tgad_pkg::POS_ATTR,
                                                 tgad_pkg::POS_ATTR + px - 1));
            end else if (sel < 80) begin
                // Huge image, a few pixels, then cut.
                start_header(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                             depth, 8'($urandom_range(255)));
                emit_file(3 * bpp, 0, $urandom_range(tgad_pkg::POS_ATTR + 1,
                                                      tgad_pkg::POS_ATTR + 3 * bpp));
            end else if (sel < 90) begin
                // Broken header with any dimensions; one or two faults.
                start_header(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                             depth, 8'($urandom_range(255)));
                repeat ($urandom_range(1, 2)) begin
                    case ($urandom_range(3))
                        0: begin
                            pos      = $urandom_range(7);
                            hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
                        end
                        1: hdr[$urandom_range(8, 11)] = 8'($urandom_range(1, 255));
                        2: begin
                            if ($urandom_range(1)) begin
                                hdr[tgad_pkg::POS_WIDTH_LO] = 8'd0;
                                hdr[tgad_pkg::POS_WIDTH_HI] = 8'd0;
                            end else begin
                                hdr[tgad_pkg::POS_HEIGHT_LO] = 8'd0;
                                hdr[tgad_pkg::POS_HEIGHT_HI] = 8'd0;
                            end
                        end
                        default: begin
                            do
                                d = 8'($urandom_range(255));
                            while (d == tgad_pkg::DEPTH_24 || d == tgad_pkg::DEPTH_32);
                            hdr[tgad_pkg::POS_DEPTH] = d;
                        end
                    endcase
                end
                emit_file(0, $urandom_range(6), -1);
            end else begin
                // File ends inside the header.
                emit_file(px, 0, $urandom_range(tgad_pkg::POS_DEPTH));
            end
        end
    endtask

    // Offer one input word; idle at random first, hold it until taken.
    task automatic send_word(t_in_word w);
        while (take_break()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w.value;
        i_s_tlast  <= w.eof;
        do
            @(posedge i_clk);
        while (!o_s_tready);
    endtask

    initial begin
        scoreboard = new();
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (file_stream[i])
            send_word(file_stream[i]);
        i_s_tvalid <= 1'b0;
        // Let the monitor note the last word, then drain what is owed.
        @(posedge i_clk);
        while (scoreboard.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
